// File: hdl/pdu_pkg.sv
// Shared types, status codes and helpers for the percent decoder with UTF-8 check.
// Used by pdu_front, pdu_queue, pdu_back and percent_decoder_utf8_check.
`default_nettype none
package pdu_pkg;

    localparam int STATUS_W   = 3;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_TRUNC  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BADHEX = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NUL    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_UTF8   = 3'd4;

    // Result item kinds
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // Allowed range of the next continuation byte
    localparam logic [2:0] CLS_ANY   = 3'd0;  // 80-BF
    localparam logic [2:0] CLS_A0_BF = 3'd1;
    localparam logic [2:0] CLS_80_9F = 3'd2;
    localparam logic [2:0] CLS_90_BF = 3'd3;
    localparam logic [2:0] CLS_80_8F = 3'd4;

    localparam logic [7:0] CHAR_PCT = 8'h25;

    typedef enum logic [2:0] {
        ESC_IDLE = 3'b001,
        ESC_HIGH = 3'b010,
        ESC_LOW  = 3'b100
    } esc_state_t;

    // Results caused by one input item
    typedef struct packed {
        logic                has_data;
        logic [7:0]          data;
        logic                has_end;
        logic [STATUS_W-1:0] status;
    } rec_t;

    // {bad, nibble}
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        r = 5'b1_0000;
        if (c >= 8'h30 && c <= 8'h39) r = {1'b0, 4'(c - 8'h30)};
        else if (c >= 8'h41 && c <= 8'h46) r = {1'b0, 4'(c - 8'h37)};
        else if (c >= 8'h61 && c <= 8'h66) r = {1'b0, 4'(c - 8'h57)};
        return r;
    endfunction

endpackage
`default_nettype wire

// File: hdl/pdu_front.sv
// Front end: escape decoding, UTF-8 check and error tracking, one byte per cycle while accept is high.
// Depends on pdu_pkg; emits one result record per item that causes results.
`default_nettype none
module pdu_front (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        accept,
    input  wire logic [7:0]  in_byte,
    input  wire logic        in_last,
    input  wire logic        require_utf8,
    output pdu_pkg::rec_t    rec,
    output logic             push
);
    import pdu_pkg::*;

    esc_state_t          esc_reg, esc_next;
    logic [3:0]          nib_reg, nib_next;
    logic                bad_reg, bad_next;
    logic [STATUS_W-1:0] err_reg, err_next;
    logic [1:0]          pend_reg, pend_next;
    logic [2:0]          cls_reg, cls_next;

    always_comb begin
        logic                have;
        logic [7:0]          dec;
        logic [STATUS_W-1:0] err;
        logic [STATUS_W-1:0] e;
        logic [4:0]          hv;
        logic [7:0]          lo;
        logic [7:0]          hi;

        esc_next  = esc_reg;
        nib_next  = nib_reg;
        bad_next  = bad_reg;
        err_next  = err_reg;
        pend_next = pend_reg;
        cls_next  = cls_reg;
        have      = 1'b0;
        dec       = '0;
        err       = err_reg;
        e         = ST_OK;
        hv        = '0;
        lo        = 8'h80;
        hi        = 8'hBF;
        rec       = '0;
        push      = 1'b0;

        if (accept) begin
            if (err_reg == ST_OK) begin
                unique case (esc_reg)
                    ESC_HIGH: begin
                        hv       = hex_value(in_byte);
                        bad_next = hv[4];
                        nib_next = hv[3:0];
                        esc_next = ESC_LOW;
                        if (in_last) err = ST_TRUNC;
                    end
                    ESC_LOW: begin
                        hv       = hex_value(in_byte);
                        esc_next = ESC_IDLE;
                        if (bad_reg || hv[4]) begin
                            err = ST_BADHEX;
                        end else begin
                            dec  = {nib_reg, hv[3:0]};
                            have = 1'b1;
                        end
                    end
                    default: begin
                        if (in_byte == CHAR_PCT) begin
                            esc_next = ESC_HIGH;
                            if (in_last) err = ST_TRUNC;
                        end else begin
                            esc_next = ESC_IDLE;
                            dec      = in_byte;
                            have     = 1'b1;
                        end
                    end
                endcase

                if (have && require_utf8) begin
                    if (dec == 8'h00) begin
                        e = ST_NUL;
                    end else if (pend_reg != 2'd0) begin
                        case (cls_reg)
                            CLS_A0_BF: lo = 8'hA0;
                            CLS_80_9F: hi = 8'h9F;
                            CLS_90_BF: lo = 8'h90;
                            CLS_80_8F: hi = 8'h8F;
                            default: ;
                        endcase
                        if (dec < lo || dec > hi) begin
                            e = ST_UTF8;
                        end else begin
                            pend_next = pend_reg - 2'd1;
                            cls_next  = CLS_ANY;
                        end
                    end else if (dec < 8'h80) begin
                        e = ST_OK;
                    end else if (dec < 8'hC2 || dec > 8'hF4) begin
                        e = ST_UTF8;
                    end else if (dec <= 8'hDF) begin
                        pend_next = 2'd1;
                        cls_next  = CLS_ANY;
                    end else if (dec <= 8'hEF) begin
                        pend_next = 2'd2;
                        cls_next  = (dec == 8'hE0) ? CLS_A0_BF :
                                    (dec == 8'hED) ? CLS_80_9F : CLS_ANY;
                    end else begin
                        pend_next = 2'd3;
                        cls_next  = (dec == 8'hF0) ? CLS_90_BF :
                                    (dec == 8'hF4) ? CLS_80_8F : CLS_ANY;
                    end
                    if (e != ST_OK) begin
                        err  = e;
                        have = 1'b0;
                    end
                end

                // sequence still open at end of value
                if (in_last && err == ST_OK && require_utf8 && pend_next != 2'd0)
                    err = ST_UTF8;
            end

            rec.has_data = have;
            rec.data     = dec;
            rec.has_end  = in_last;
            rec.status   = in_last ? err : ST_OK;
            push         = have | in_last;

            if (in_last) begin
                esc_next  = ESC_IDLE;
                nib_next  = '0;
                bad_next  = 1'b0;
                err_next  = ST_OK;
                pend_next = '0;
                cls_next  = CLS_ANY;
            end else begin
                err_next = err;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            esc_reg  <= ESC_IDLE;
            nib_reg  <= '0;
            bad_reg  <= 1'b0;
            err_reg  <= ST_OK;
            pend_reg <= '0;
            cls_reg  <= CLS_ANY;
        end else begin
            esc_reg  <= esc_next;
            nib_reg  <= nib_next;
            bad_reg  <= bad_next;
            err_reg  <= err_next;
            pend_reg <= pend_next;
            cls_reg  <= cls_next;
        end
    end

endmodule
`default_nettype wire

// File: hdl/pdu_queue.sv
// Short FIFO of result records between the front end and the output stage.
// Depends on pdu_pkg for rec_t and the depth constants.
`default_nettype none
module pdu_queue (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         push,
    input  wire pdu_pkg::rec_t push_rec,
    input  wire logic         pop,
    output pdu_pkg::rec_t     head_rec,
    output logic              empty,
    output logic              full
);
    import pdu_pkg::*;

    rec_t               mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_AW:0]   count_reg, count_next;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign head_rec = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) count_next = count_reg + 1'b1;
        else if (!push && pop) count_next = count_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_ptr_reg] <= push_rec;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule
`default_nettype wire

// File: hdl/pdu_back.sv
// Output stage: expands each record into a data item and/or an end item.
// Depends on pdu_pkg; drives the registered result channel.
`default_nettype none
module pdu_back (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire pdu_pkg::rec_t                 head_rec,
    input  wire logic                          empty,
    output logic                               pop,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic                               m_kind,
    output logic [7:0]                         m_data,
    output logic [pdu_pkg::STATUS_W-1:0]       m_status,
    output logic                               m_last
);
    import pdu_pkg::*;

    logic                valid_reg;
    logic                kind_reg;
    logic [7:0]          data_reg;
    logic [STATUS_W-1:0] status_reg;
    logic                last_reg;
    logic                pend_reg;      // end item still owed for the popped record
    logic [STATUS_W-1:0] pend_status_reg;
    logic                load;

    assign load = !valid_reg || m_ready;
    assign pop  = load && !pend_reg && !empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end else if (load) begin
            if (pend_reg) begin
                valid_reg <= 1'b1;
                pend_reg  <= 1'b0;
            end else if (!empty) begin
                valid_reg <= 1'b1;
                pend_reg  <= head_rec.has_data && head_rec.has_end;
            end else begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            if (pend_reg) begin
                kind_reg   <= KIND_END;
                data_reg   <= '0;
                status_reg <= pend_status_reg;
                last_reg   <= 1'b1;
            end else if (head_rec.has_data) begin
                kind_reg   <= KIND_DATA;
                data_reg   <= head_rec.data;
                status_reg <= ST_OK;
                last_reg   <= !head_rec.has_end;
            end else begin
                kind_reg   <= KIND_END;
                data_reg   <= '0;
                status_reg <= head_rec.status;
                last_reg   <= 1'b1;
            end
            if (!pend_reg) pend_status_reg <= head_rec.status;
        end
    end

    assign m_valid  = valid_reg;
    assign m_kind   = kind_reg;
    assign m_data   = data_reg;
    assign m_status = status_reg;
    assign m_last   = last_reg;

endmodule
`default_nettype wire

// File: hdl/percent_decoder_utf8_check.sv
// Percent decoder with optional strict UTF-8 check: top level with APB register.
// An accepted item is written into the queue, then registered in pdu_back before it shows on m_.
// Throughput: 1 item/cycle while the queue is not full; an item giving data plus end status
// yields two output items, so a steady run of those fills the 4-entry queue and stalls s_tready.
// Reset: synchronous active-low aresetn clears decode state, queue and require_utf8.
// Depends on pdu_pkg, pdu_front, pdu_queue and pdu_back.
`default_nettype none
module percent_decoder_utf8_check (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [7:0] data, [10:8] status, rest zero
    output logic [0:0]       m_tuser,   // [0] kind
    output logic             m_tlast,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import pdu_pkg::*;

    logic                require_utf8_reg;
    logic                accept;
    logic                push;
    logic                pop;
    logic                empty;
    logic                full;
    rec_t                front_rec;
    rec_t                head_rec;
    logic                out_kind;
    logic [7:0]          out_data;
    logic [STATUS_W-1:0] out_status;

    assign pready = 1'b1;
    assign prdata = {31'd0, require_utf8_reg & ~paddr[2]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            require_utf8_reg <= 1'b0;
        end else if (psel && penable && pwrite && pready && !paddr[2]) begin
            require_utf8_reg <= pwdata[0];
        end
    end

    assign s_tready = !full;
    assign accept   = s_tvalid && s_tready;

    pdu_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (accept),
        .in_byte      (s_tdata),
        .in_last      (s_tlast),
        .require_utf8 (require_utf8_reg),
        .rec          (front_rec),
        .push         (push)
    );

    pdu_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_rec (front_rec),
        .pop      (pop),
        .head_rec (head_rec),
        .empty    (empty),
        .full     (full)
    );

    pdu_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head_rec (head_rec),
        .empty    (empty),
        .pop      (pop),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_kind   (out_kind),
        .m_data   (out_data),
        .m_status (out_status),
        .m_last   (m_tlast)
    );

    assign m_tdata = {5'd0, out_status, out_data};
    assign m_tuser = out_kind;

endmodule
`default_nettype wire
